// ===== hdl/dac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dac_pkg;

    localparam int CordicStepsDefault = 24;
    localparam int CordicStepsMax     = 32;

    // CORDIC vector width, angle width, coefficient width, lambda width
    localparam int XW = 58;
    localparam int ZW = 35;
    localparam int CW = 40;
    localparam int LW = 23;
    // Polynomial accumulator, divisor and partial remainder widths
    localparam int PW = 42;
    localparam int DW = 41;
    localparam int RW = 42;

    localparam logic signed [CW-1:0] CoeffConstReset  = 40'sd1041749686;
    localparam logic signed [CW-1:0] CoeffLinearReset = 40'sd825293428;
    localparam logic signed [CW-1:0] CoeffSquareReset = 40'sd12435030;
    localparam logic signed [CW-1:0] CoeffCubeReset   = 40'sd4195337240;

    localparam logic [1:0] RegCoeffConst  = 2'd0;
    localparam logic [1:0] RegCoeffLinear = 2'd1;
    localparam logic [1:0] RegCoeffSquare = 2'd2;
    localparam logic [1:0] RegCoeffCube   = 2'd3;

    localparam logic [29:0] DegPerRadQ24 = 30'd961263669;
    localparam logic [LW-1:0] LambdaMaxQ16 = 23'd5898240;

    // atan(2^-i) in radians with 32 fraction bits, rounded to nearest.
    localparam logic [31:0] AtanQ32 [CordicStepsMax] = '{
        32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
        32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
        32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
        32'd1048576,    32'd524288,     32'd262144,     32'd131072,
        32'd65536,      32'd32768,      32'd16384,      32'd8192,
        32'd4096,       32'd2048,       32'd1024,       32'd512,
        32'd256,        32'd128,        32'd64,         32'd32,
        32'd16,         32'd8,          32'd4,          32'd2
    };

    typedef struct packed {
        logic [31:0]           raw;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [ZW-1:0]  z;
    } cordic_t;

    typedef struct packed {
        logic [1:0]    low;
        logic [RW-1:0] rem;
        logic [DW-1:0] div;
        logic [31:0]   quo;
        logic          bad;
    } divq_t;

endpackage
`default_nettype wire

// ===== hdl/dedx_angular_correction.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Angular correction of dE/dx: one track per transfer in, one result per
// transfer out, in order. A new track is taken every cycle that s_tready is
// high. Path: input register, one CORDIC cell per step, nine polynomial
// stages, 32 divider cells, output register. The row of cells moves together,
// so input is held off only when the output register holds an untaken result
// and the last divider cell is also occupied. The user must write coefficients
// via cfg only while no track is in flight; the block does not enforce this.
module dedx_angular_correction
    import dac_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [63:0]   s_tdata,   // raw_dedx [31:0], dip_slope [63:32]
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,   // corrected_dedx [31:0]
    output logic               m_tuser,   // bad_divisor [0]
    input  wire logic          cfg_wr_en,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [CW-1:0] cfg_wdata
);

    logic signed [CW-1:0] coeff_const_reg, coeff_linear_reg;
    logic signed [CW-1:0] coeff_square_reg, coeff_cube_reg;

    logic        out_free, adv;
    logic        in_valid_reg;
    cordic_t     in_reg, in_next;
    logic [32:0] slope_mag;

    logic        cd_valid [CORDIC_STEPS+1];
    cordic_t     cd_data  [CORDIC_STEPS+1];
    logic        dv_valid [33];
    divq_t       dv_data  [33];

    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic        m_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_const_reg  <= CoeffConstReset;
            coeff_linear_reg <= CoeffLinearReset;
            coeff_square_reg <= CoeffSquareReset;
            coeff_cube_reg   <= CoeffCubeReset;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                RegCoeffConst:  coeff_const_reg  <= cfg_wdata;
                RegCoeffLinear: coeff_linear_reg <= cfg_wdata;
                RegCoeffSquare: coeff_square_reg <= cfg_wdata;
                RegCoeffCube:   coeff_cube_reg   <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign adv      = out_free || !dv_valid[32];
    assign s_tready = adv;

    // The most negative slope keeps its magnitude of 2^31 in 33 bits.
    assign slope_mag = s_tdata[63] ? (33'd0 - {1'b1, s_tdata[63:32]})
                                   : {1'b0, s_tdata[63:32]};

    always_comb begin
        in_next.raw = s_tdata[31:0];
        in_next.x   = XW'(64'd1 << 44);
        in_next.y   = XW'({slope_mag, 24'd0});
        in_next.z   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg <= in_next;
        end
    end

    assign cd_valid[0] = in_valid_reg;
    assign cd_data[0]  = in_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        dac_cordic_cell #(
            .Shift(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_valid (cd_valid[i]),
            .in_data  (cd_data[i]),
            .out_valid(cd_valid[i+1]),
            .out_data (cd_data[i+1])
        );
    end

    dac_poly u_poly (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in_valid    (cd_valid[CORDIC_STEPS]),
        .in_data     (cd_data[CORDIC_STEPS]),
        .coeff_const (coeff_const_reg),
        .coeff_linear(coeff_linear_reg),
        .coeff_square(coeff_square_reg),
        .coeff_cube  (coeff_cube_reg),
        .out_valid   (dv_valid[0]),
        .out_data    (dv_data[0])
    );

    for (genvar j = 0; j < 32; j++) begin : g_div
        dac_div_cell #(
            .Step(j)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_valid (dv_valid[j]),
            .in_data  (dv_data[j]),
            .out_valid(dv_valid[j+1]),
            .out_data (dv_data[j+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= dv_valid[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= dv_data[32].bad ? 32'hFFFF_FFFF : dv_data[32].quo;
            m_bad_reg  <= dv_data[32].bad;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_bad_reg;

`ifndef NO_ASSERTIONS
    a_hold_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && dv_valid[32]))
        else $error("input held off while the row of cells could move");

    a_bad_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'hFFFF_FFFF))
        else $error("flagged result is not saturated");

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_valid[16] && !dv_data[16].bad) |-> (dv_data[16].rem < {1'b0, dv_data[16].div}))
        else $error("partial remainder reached the divisor");

    a_last_moves_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_valid[32] && out_free) |=> m_tvalid)
        else $error("result lost between divider and output register");
`endif

endmodule
`default_nettype wire

// ===== hdl/dac_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dac_cordic_cell
    import dac_pkg::*;
#(
    parameter int Shift = 0
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire cordic_t in_data,
    output logic         out_valid,
    output cordic_t      out_data
);

    localparam logic signed [ZW-1:0] Angle = ZW'(AtanQ32[Shift]);

    logic signed [XW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in;
    logic                 valid_reg;
    cordic_t              data_reg, data_next;

    assign x_in = in_data.x;
    assign y_in = in_data.y;
    assign z_in = in_data.z;
    assign dx   = y_in >>> Shift;
    assign dy   = x_in >>> Shift;

    always_comb begin
        data_next     = in_data;
        if (!y_in[XW-1]) begin
            data_next.x = x_in + dx;
            data_next.y = y_in - dy;
            data_next.z = z_in + Angle;
        end else begin
            data_next.x = x_in - dx;
            data_next.y = y_in + dy;
            data_next.z = z_in - Angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ===== hdl/dac_poly.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dac_poly
    import dac_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire cordic_t              in_data,
    input  wire logic signed [CW-1:0] coeff_const,
    input  wire logic signed [CW-1:0] coeff_linear,
    input  wire logic signed [CW-1:0] coeff_square,
    input  wire logic signed [CW-1:0] coeff_cube,
    output logic                      out_valid,
    output divq_t                     out_data
);

    localparam int Stages = 9;

    logic [Stages-1:0] vld_reg;
    logic [31:0]       raw_reg [Stages-1];

    logic signed [ZW-1:0]   z_in;
    logic [32:0]            z_clamped;
    logic [62:0]            deg_prod_reg;
    logic [LW-1:0]          deg_raw;
    logic signed [LW:0]     l_reg [5];
    logic signed [63:0]     m1_reg;
    logic signed [PW-1:0]   a1_reg;
    logic signed [PW+23:0]  m2_reg;
    logic signed [PW-1:0]   a2_reg;
    logic signed [PW+23:0]  m3_reg;
    logic signed [PW-1:0]   p_reg;
    divq_t                  out_reg, out_next;

    assign z_in      = in_data.z;
    assign z_clamped = z_in[ZW-1] ? 33'd0 : z_in[32:0];
    assign deg_raw   = deg_prod_reg[62:40];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Stages-2:0], in_valid};
        end
    end

    always_comb begin
        out_next     = '0;
        out_next.low = raw_reg[Stages-2][1:0];
        out_next.rem = RW'(raw_reg[Stages-2][31:2]);
        out_next.div = p_reg[DW-1:0];
        out_next.bad = (p_reg <= 0) ||
                       ($signed({12'd0, raw_reg[Stages-2][31:2]}) >= p_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            raw_reg[0]   <= in_data.raw;
            for (int i = 1; i < Stages - 1; i++) begin
                raw_reg[i] <= raw_reg[i-1];
            end
            deg_prod_reg <= z_clamped * DegPerRadQ24;
            l_reg[0]     <= (deg_raw > LambdaMaxQ16) ? {1'b0, LambdaMaxQ16}
                                                      : {1'b0, deg_raw};
            for (int i = 1; i < 5; i++) begin
                l_reg[i] <= l_reg[i-1];
            end
            m1_reg  <= coeff_cube * l_reg[0];
            a1_reg  <= PW'(coeff_square) + PW'(m1_reg >>> 24);
            m2_reg  <= a1_reg * l_reg[2];
            a2_reg  <= PW'(coeff_linear) + PW'(m2_reg >>> 24);
            m3_reg  <= a2_reg * l_reg[4];
            p_reg   <= PW'(coeff_const) + PW'(m3_reg >>> 26);
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[Stages-1];
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== hdl/dac_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dac_div_cell
    import dac_pkg::*;
#(
    parameter int Step = 0
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire divq_t in_data,
    output logic       out_valid,
    output divq_t      out_data
);

    logic          next_bit;
    logic [RW-1:0] trial;
    logic          ge;
    logic          valid_reg;
    divq_t         data_reg, data_next;

    // The dividend is raw shifted up by 30: its two lowest raw bits come down
    // first, then zeros.
    always_comb begin
        if (Step == 0) begin
            next_bit = in_data.low[1];
        end else if (Step == 1) begin
            next_bit = in_data.low[0];
        end else begin
            next_bit = 1'b0;
        end
    end

    assign trial = {in_data.rem[RW-2:0], next_bit};
    assign ge    = trial >= {1'b0, in_data.div};

    always_comb begin
        data_next     = in_data;
        data_next.rem = ge ? (trial - {1'b0, in_data.div}) : trial;
        data_next.quo = {in_data.quo[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire
